// ----- hdl/cso_pkg.sv -----
// ----------------------------------------------------------------------------
// cso_pkg: shared types and constants for the RGB555 scan-out block
// Holds the screen geometry, cursor geometry, the queue entry layout and the
// channel widening function used by the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cso_pkg;

  // Screen geometry.
  localparam int LINE_PIXELS = 640;
  localparam int FRAME_LINES = 480;
  localparam int COL_W       = $clog2(LINE_PIXELS);
  localparam int ROW_W       = $clog2(FRAME_LINES);

  // Cursor geometry and position registers.
  localparam int CURSOR_SIDE = 32;
  localparam int CUR_W       = $clog2(CURSOR_SIDE);
  localparam int ADDR_W      = 2 * CUR_W;
  localparam int RAM_DEPTH   = CURSOR_SIDE * CURSOR_SIDE;
  localparam int POS_W       = 12;

  // Pixel and cursor entry layout.
  localparam int CHAN_W      = 5;
  localparam int OUT_CHAN_W  = 8;
  localparam int COLOR_W     = 3 * CHAN_W;
  localparam int WORD_W      = 16;
  localparam int OPAQUE_BIT  = 15;

  // Stream widths.
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 24;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_CURSOR_COL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CURSOR_ROW = 2'd1;

  // Command queue between front and back.
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  // Item kinds.
  typedef enum logic {
    OP_PIXEL     = 1'b0,
    OP_CURSOR_WR = 1'b1
  } op_e;

  // One queued command: a pixel to draw or a cursor RAM write.
  typedef struct packed {
    op_e                op;
    logic [COLOR_W-1:0] pixel;
    logic [ADDR_W-1:0]  addr;
    logic               hit;
    logic               line_end;
    logic               frame_end;
    logic [WORD_W-1:0]  wdata;
  } cmd_t;

  // Widen a 5-bit channel to 8 bits by repeating its top bits.
  function automatic logic [OUT_CHAN_W-1:0] widen5(input logic [CHAN_W-1:0] c);
    widen5 = {c, c[CHAN_W-1:CHAN_W-(OUT_CHAN_W-CHAN_W)]};
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rgb555_scanout_with_cursor.sv -----
// A pixel goes through the queue, the read stage and the output register to m_tvalid.
// Throughput: one item per cycle unless stalled; cursor writes produce no output pixel.
// The cursor RAM has one write and one read port, shared in queue order.
// Reset: counters and cursor position go to zero, then a clearing pass
// zeroes all 1024 cursor RAM entries; s_tready stays low during that pass.
// Configuration writes are taken at any time outside reset.
// ----------------------------------------------------------------------------
// rgb555_scanout_with_cursor: RGB555 scan-out with hardware cursor
// Front part tracks the raster and classifies items, a short queue decouples
// it from the back part, which owns the cursor RAM and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb555_scanout_with_cursor (
  input  wire                                 clk,
  input  wire                                 rst,
  // Input stream.
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // s_tdata: pixel_word [15:0], cursor_index [25:16], cursor_data [41:26], zero pad
  input  wire [cso_pkg::S_TDATA_W-1:0]        s_tdata,
  // s_tuser: opcode [0]
  input  wire                                 s_tuser,
  // Output stream.
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // m_tdata: red [7:0], green [15:8], blue [23:16]
  output logic [cso_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic                                m_tlast,
  // m_tuser: frame_end [0]
  output logic                                m_tuser,
  // Configuration write channel.
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [cso_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire [cso_pkg::POS_W-1:0]            cfg_data
);

  localparam int PW_LO = 0;
  localparam int CI_LO = PW_LO + cso_pkg::WORD_W;
  localparam int CD_LO = CI_LO + cso_pkg::ADDR_W;

  logic          accept;
  logic          push;
  logic          pop;
  logic          full;
  logic          busy;
  logic          head_valid;
  cso_pkg::cmd_t push_cmd;
  cso_pkg::cmd_t head_cmd;
  cso_pkg::op_e  opcode;

  assign opcode    = cso_pkg::op_e'(s_tuser);
  assign s_tready  = !busy && !full;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = !rst;

  cso_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .opcode       (opcode),
    .pixel_word   (s_tdata[PW_LO +: cso_pkg::WORD_W]),
    .cursor_index (s_tdata[CI_LO +: cso_pkg::ADDR_W]),
    .cursor_data  (s_tdata[CD_LO +: cso_pkg::WORD_W]),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .cmd          (push_cmd)
  );

  cso_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  cso_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .busy       (busy),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

// ----- hdl/cso_front.sv -----
// ----------------------------------------------------------------------------
// cso_front: item classification and raster position tracking
// Keeps the column and row counters and the cursor position registers, and
// turns each accepted item into a queue command with its cursor RAM address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cso_front (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 accept,
  input  wire cso_pkg::op_e                   opcode,
  input  wire [cso_pkg::WORD_W-1:0]           pixel_word,
  input  wire [cso_pkg::ADDR_W-1:0]           cursor_index,
  input  wire [cso_pkg::WORD_W-1:0]           cursor_data,
  input  wire                                 cfg_valid,
  input  wire [cso_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire [cso_pkg::POS_W-1:0]            cfg_data,
  output logic                                push,
  output cso_pkg::cmd_t                       cmd
);

  logic [cso_pkg::COL_W-1:0] column_count;
  logic [cso_pkg::ROW_W-1:0] row_count;
  logic [cso_pkg::POS_W-1:0] cursor_col;
  logic [cso_pkg::POS_W-1:0] cursor_row;
  logic [cso_pkg::POS_W-1:0] dx;
  logic [cso_pkg::POS_W-1:0] dy;
  logic                      last_col;
  logic                      last_row;
  logic                      pixel_xfer;

  // Offsets from the cursor corner wrap at the position register width.
  assign dx       = cso_pkg::POS_W'(column_count) - cursor_col;
  assign dy       = cso_pkg::POS_W'(row_count) - cursor_row;
  assign last_col = column_count >= cso_pkg::COL_W'(cso_pkg::LINE_PIXELS - 1);
  assign last_row = row_count >= cso_pkg::ROW_W'(cso_pkg::FRAME_LINES - 1);

  assign pixel_xfer = accept && (opcode == cso_pkg::OP_PIXEL);

  // Build the queue command for this transfer.
  always_comb begin
    push          = accept;
    cmd.op        = opcode;
    cmd.pixel     = pixel_word[cso_pkg::COLOR_W-1:0];
    cmd.wdata     = cursor_data;
    cmd.line_end  = last_col;
    cmd.frame_end = last_col && last_row;
    cmd.hit       = (dx < cso_pkg::POS_W'(cso_pkg::CURSOR_SIDE)) &&
                    (dy < cso_pkg::POS_W'(cso_pkg::CURSOR_SIDE));
    if (opcode == cso_pkg::OP_CURSOR_WR) begin
      cmd.addr = cursor_index;
    end else begin
      cmd.addr = {dy[cso_pkg::CUR_W-1:0], dx[cso_pkg::CUR_W-1:0]};
    end
  end

  // Raster counters advance on each pixel transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (pixel_xfer) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // Cursor position registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == cso_pkg::REG_CURSOR_COL) begin
        cursor_col <= cfg_data;
      end
      if (cfg_index == cso_pkg::REG_CURSOR_ROW) begin
        cursor_row <= cfg_data;
      end
    end
  end

  // The counters stay inside the screen.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    column_count < cso_pkg::COL_W'(cso_pkg::LINE_PIXELS))
    else $error("column counter out of range");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_count < cso_pkg::ROW_W'(cso_pkg::FRAME_LINES))
    else $error("row counter out of range");

  // A frame end is always also a line end.
  a_frame_line: assert property (@(posedge clk) disable iff (rst)
    push |-> (!cmd.frame_end || cmd.line_end))
    else $error("frame end without line end");

endmodule

`default_nettype wire

// ----- hdl/cso_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// cso_cmd_queue: short command queue between front and back
// A small register FIFO that lets the front keep taking items while the
// back part waits on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cso_cmd_queue (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push,
  input  wire cso_pkg::cmd_t           push_cmd,
  output logic                         full,
  input  wire                          pop,
  output logic                         head_valid,
  output cso_pkg::cmd_t                head_cmd
);

  cso_pkg::cmd_t               entries [cso_pkg::Q_DEPTH];
  logic [cso_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [cso_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [cso_pkg::Q_CNT_W-1:0] count;

  assign full       = count == cso_pkg::Q_CNT_W'(cso_pkg::Q_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= cso_pkg::Q_CNT_W'(cso_pkg::Q_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- hdl/cso_back.sv -----
// ----------------------------------------------------------------------------
// cso_back: cursor RAM, overlay and pixel output
// Carries out queued commands: cursor writes go into the cursor RAM, pixels
// read the RAM, merge the cursor colour and leave through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cso_back (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 head_valid,
  input  wire cso_pkg::cmd_t                  head_cmd,
  output logic                                pop,
  output logic                                busy,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [cso_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic                                m_tlast,
  output logic                                m_tuser
);

  logic [cso_pkg::WORD_W-1:0]  mem [cso_pkg::RAM_DEPTH];
  logic [cso_pkg::WORD_W-1:0]  rd_data;
  logic                        clearing;
  logic [cso_pkg::ADDR_W-1:0]  clr_addr;

  // Read stage.
  logic                        a_valid;
  logic [cso_pkg::COLOR_W-1:0] a_pixel;
  logic                        a_hit;
  logic                        a_line_end;
  logic                        a_frame_end;

  // Output register.
  logic                        b_valid;
  logic [cso_pkg::COLOR_W-1:0] b_color;
  logic                        b_line_end;
  logic                        b_frame_end;

  logic                        b_load;
  logic                        a_free;
  logic                        head_is_write;
  logic [cso_pkg::COLOR_W-1:0] merged;

  assign busy          = clearing;
  assign head_is_write = head_cmd.op == cso_pkg::OP_CURSOR_WR;
  assign b_load        = a_valid && (!b_valid || m_tready);
  assign a_free        = !a_valid || b_load;
  assign pop           = head_valid && !clearing && (head_is_write || a_free);

  // An opaque cursor entry replaces the framebuffer colour.
  assign merged = (a_hit && rd_data[cso_pkg::OPAQUE_BIT]) ?
                  rd_data[cso_pkg::COLOR_W-1:0] : a_pixel;

  // Clearing pass after reset, one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == cso_pkg::ADDR_W'(cso_pkg::RAM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Cursor RAM: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (pop && head_is_write) begin
      mem[head_cmd.addr] <= head_cmd.wdata;
    end
    if (pop && !head_is_write) begin
      rd_data <= mem[head_cmd.addr];
    end
  end

  // Read stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pop && !head_is_write) begin
      a_valid <= 1'b1;
    end else if (b_load) begin
      a_valid <= 1'b0;
    end
  end

  // Read stage payload.
  always_ff @(posedge clk) begin
    if (pop && !head_is_write) begin
      a_pixel     <= head_cmd.pixel;
      a_hit       <= head_cmd.hit;
      a_line_end  <= head_cmd.line_end;
      a_frame_end <= head_cmd.frame_end;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= 1'b1;
    end else if (m_tready) begin
      b_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (b_load) begin
      b_color     <= merged;
      b_line_end  <= a_line_end;
      b_frame_end <= a_frame_end;
    end
  end

  // Widen each channel on the way out: red, green, blue from the low byte up.
  assign m_tvalid = b_valid;
  assign m_tdata  = {cso_pkg::widen5(b_color[0 +: cso_pkg::CHAN_W]),
                     cso_pkg::widen5(b_color[cso_pkg::CHAN_W +: cso_pkg::CHAN_W]),
                     cso_pkg::widen5(b_color[2*cso_pkg::CHAN_W +: cso_pkg::CHAN_W])};
  assign m_tlast  = b_line_end;
  assign m_tuser  = b_frame_end;

  a_no_pop_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop)
    else $error("command taken during clearing pass");

  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    (pop && !head_is_write && a_valid) |-> b_load)
    else $error("pixel read would overwrite held read stage");

  a_held_read: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !b_load) |=> a_valid && $stable(rd_data))
    else $error("stalled read data changed");

endmodule

`default_nettype wire
